// ----- src/gb3_pkg.sv -----
// gb3_pkg: shared constants, types and codes of the 3x3 Gaussian blur block.
// No dependencies; imported by every module under src.
`default_nettype none

package gb3_pkg;

  localparam int MAX_WIDTH    = 512;
  localparam int PIXEL_BITS   = 8;
  localparam int ADDR_BITS    = $clog2(MAX_WIDTH);
  localparam int DIM_BITS     = 10;
  localparam int ROW_BITS     = DIM_BITS + 1;
  localparam int CFG_IDX_BITS = 2;

  typedef logic [PIXEL_BITS-1:0]   pix_t;
  typedef logic [ADDR_BITS-1:0]    addr_t;
  typedef logic [DIM_BITS-1:0]     dim_t;
  typedef logic [ROW_BITS-1:0]     row_t;
  typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_FLUSH = 1'b1
  } op_t;

  localparam cfg_idx_t REG_IMAGE_WIDTH  = cfg_idx_t'(0);
  localparam cfg_idx_t REG_IMAGE_HEIGHT = cfg_idx_t'(1);

  localparam dim_t WIDTH_MAX = dim_t'(MAX_WIDTH);
  localparam dim_t CFG_RESET = dim_t'(512);

  // per-request decision made when the request is accepted
  typedef struct packed {
    logic push;    // shift a pixel into the row stores and window
    logic emit;    // produce a result
    logic drain;   // one-row frame: result comes straight from the middle store
    logic border;  // result is on the frame border, pass the center through
    logic last;    // result closes the frame
  } item_ctl_t;

endpackage

`default_nettype wire

// ----- src/gb3_ctrl.sv -----
// gb3_ctrl: raster position counters, frame geometry latch and per-request decision.
// Depends on gb3_pkg.
`default_nettype none

module gb3_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  gb3_pkg::op_t       op,
  input  gb3_pkg::pix_t      pix,
  input  gb3_pkg::dim_t      cfg_width,
  input  gb3_pkg::dim_t      cfg_height,
  output gb3_pkg::item_ctl_t ctl,
  output gb3_pkg::addr_t     push_col,
  output gb3_pkg::addr_t     store_addr,
  output gb3_pkg::pix_t      push_pix
);
  import gb3_pkg::*;

  addr_t in_col_r, in_col_nxt;
  row_t  in_row_r, in_row_nxt;
  addr_t out_col_r, out_col_nxt;
  dim_t  out_row_r, out_row_nxt;
  dim_t  frame_w_r, frame_w_nxt;
  dim_t  frame_h_r, frame_h_nxt;

  logic start, full, in_wrap, out_wrap;
  dim_t clamp_w, clamp_h, eff_w, eff_h, in_col_inc, out_col_inc;

  always_comb begin
    start = (in_row_r == '0) && (in_col_r == '0) && (out_row_r == '0) && (out_col_r == '0);

    clamp_w = cfg_width;
    if (cfg_width == '0) begin
      clamp_w = dim_t'(1);
    end else if (cfg_width > WIDTH_MAX) begin
      clamp_w = WIDTH_MAX;
    end
    clamp_h = (cfg_height == '0) ? dim_t'(1) : cfg_height;

    // geometry is taken from the registers only at the start of a frame
    eff_w = start ? clamp_w : frame_w_r;
    eff_h = start ? clamp_h : frame_h_r;

    full = in_row_r >= row_t'(eff_h);

    ctl.drain  = full && (eff_h == dim_t'(1));
    ctl.push   = !ctl.drain && ((op == OP_PIXEL) || full);
    // first result needs width+1 pixels already stored
    ctl.emit   = ctl.drain ||
                 (ctl.push && ((in_row_r >= row_t'(2)) ||
                               ((in_row_r == row_t'(1)) && (in_col_r != '0))));
    ctl.border = (out_row_r == '0) || (out_row_r >= eff_h - dim_t'(1)) ||
                 (out_col_r == '0) || (dim_t'(out_col_r) >= eff_w - dim_t'(1));
    ctl.last   = (out_row_r == eff_h - dim_t'(1)) &&
                 (dim_t'(out_col_r) == eff_w - dim_t'(1));

    push_col   = in_col_r;
    store_addr = ctl.drain ? out_col_r : in_col_r;
    push_pix   = full ? '0 : pix;   // pixels past the frame act as zero flushes

    in_col_inc  = dim_t'(in_col_r) + dim_t'(1);
    in_wrap     = in_col_inc == eff_w;
    out_col_inc = dim_t'(out_col_r) + dim_t'(1);
    out_wrap    = out_col_inc == eff_w;

    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    frame_w_nxt = frame_w_r;
    frame_h_nxt = frame_h_r;

    if (accept) begin
      if (start) begin
        frame_w_nxt = clamp_w;
        frame_h_nxt = clamp_h;
      end
      if (ctl.push) begin
        if (in_wrap) begin
          in_col_nxt = '0;
          in_row_nxt = in_row_r + row_t'(1);
        end else begin
          in_col_nxt = in_col_inc[ADDR_BITS-1:0];
        end
      end
      if (ctl.emit) begin
        if (ctl.last) begin
          in_col_nxt  = '0;
          in_row_nxt  = '0;
          out_col_nxt = '0;
          out_row_nxt = '0;
        end else if (out_wrap) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + dim_t'(1);
        end else begin
          out_col_nxt = out_col_inc[ADDR_BITS-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      frame_w_r <= dim_t'(1);
      frame_h_r <= dim_t'(1);
    end else begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      frame_w_r <= frame_w_nxt;
      frame_h_r <= frame_h_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- src/gb3_line_store.sv -----
// gb3_line_store: the two row memories (upper and middle) with registered reads.
// Depends on gb3_pkg.
`default_nettype none

module gb3_line_store (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           rd_en,
  input  gb3_pkg::addr_t rd_addr_up,
  input  gb3_pkg::addr_t rd_addr_mid,
  input  logic           mid_we,
  input  gb3_pkg::addr_t mid_waddr,
  input  gb3_pkg::pix_t  mid_wdata,
  input  logic           up_we,
  input  gb3_pkg::addr_t up_waddr,
  output gb3_pkg::pix_t  up_q,
  output gb3_pkg::pix_t  mid_q
);
  import gb3_pkg::*;

  pix_t upper_mem  [MAX_WIDTH];
  pix_t middle_mem [MAX_WIDTH];

  pix_t up_rd_r, mid_rd_r, fwd_data_r;
  logic fwd_r;

  // middle row: new pixel written at accept, old value read at the same edge
  always_ff @(posedge clk) begin
    if (mid_we) begin
      middle_mem[mid_waddr] <= mid_wdata;
    end
    if (rd_en) begin
      mid_rd_r <= middle_mem[rd_addr_mid];
    end
  end

  // upper row takes the old middle value from the registered middle read on up_we
  always_ff @(posedge clk) begin
    if (up_we) begin
      upper_mem[up_waddr] <= mid_rd_r;
    end
    if (rd_en) begin
      up_rd_r <= upper_mem[rd_addr_up];
    end
  end

  // same-column write and read on one edge (one-pixel rows): bypass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else if (rd_en) begin
      fwd_r <= up_we && (up_waddr == rd_addr_up);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_data_r <= mid_rd_r;
    end
  end

  assign up_q  = fwd_r ? fwd_data_r : up_rd_r;
  assign mid_q = mid_rd_r;

endmodule

`default_nettype wire

// ----- src/gb3_window.sv -----
// gb3_window: 3x3 window (2 registered columns + new), 1-2-1 weighted sum, result select.
// Depends on gb3_pkg.
`default_nettype none

module gb3_window (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          shift_en,
  input  gb3_pkg::pix_t new_up,
  input  gb3_pkg::pix_t new_mid,
  input  gb3_pkg::pix_t new_low,
  input  logic          drain,
  input  logic          border,
  input  gb3_pkg::pix_t store_pix,
  output gb3_pkg::pix_t result
);
  import gb3_pkg::*;

  localparam int SHIFT    = 4;
  localparam int SUM_BITS = PIXEL_BITS + SHIFT;

  // only the two newest columns are kept; the oldest drops out on each shift
  pix_t win_r [3][2];
  pix_t new_col [3];
  pix_t tap [3][3];
  logic [SUM_BITS-1:0] sum;

  always_comb begin
    new_col[0] = new_up;
    new_col[1] = new_mid;
    new_col[2] = new_low;
    for (int r = 0; r < 3; r++) begin
      tap[r][0] = win_r[r][0];
      tap[r][1] = win_r[r][1];
      tap[r][2] = new_col[r];
    end

    sum = SUM_BITS'(tap[0][0]) + (SUM_BITS'(tap[0][1]) << 1) + SUM_BITS'(tap[0][2])
        + (SUM_BITS'(tap[1][0]) << 1) + (SUM_BITS'(tap[1][1]) << 2)
        + (SUM_BITS'(tap[1][2]) << 1)
        + SUM_BITS'(tap[2][0]) + (SUM_BITS'(tap[2][1]) << 1) + SUM_BITS'(tap[2][2]);

    if (drain) begin
      result = store_pix;
    end else if (border) begin
      result = tap[1][1];
    end else begin
      result = sum[SUM_BITS-1:SHIFT];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < 3; r++) begin
        win_r[r][0] <= '0;
        win_r[r][1] <= '0;
      end
    end else if (shift_en) begin
      for (int r = 0; r < 3; r++) begin
        win_r[r][0] <= win_r[r][1];
        win_r[r][1] <= new_col[r];
      end
    end
  end

endmodule

`default_nettype wire

// ----- src/gaussian_blur_3x3_top.sv -----
// gaussian_blur_3x3_top: streaming 3x3 Gaussian blur (1-2-1 / 2-4-2 / 1-2-1, >>4).
// Depends on gb3_pkg, gb3_ctrl, gb3_line_store, gb3_window.
// Throughput: one request per clock while the output register is not stuck; the row
// memories take one read and one write per port each cycle, so they never limit the rate.
// Path: the request that completes a result fills the read stage, and the result then
// goes into the output register, from which it leaves; in a frame of two rows or more,
// output pixel k is completed by the frame's non-ignored request k+width+1, from 0.
// Reset: synchronous, active low; clears counters, window and handshake state,
// sets both geometry registers to 512. Row memories are not cleared.
`default_nettype none

module gaussian_blur_3x3_top (
  input  logic             clk,
  input  logic             rst_n,
  // pixel / flush requests
  input  logic             in_valid,
  output logic             in_ready,
  input  gb3_pkg::op_t     in_operation,
  input  gb3_pkg::pix_t    in_pixel_in,
  // results
  output logic             out_valid,
  input  logic             out_ready,
  output gb3_pkg::pix_t    out_pixel_out,
  output logic             out_frame_end,
  // geometry registers
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  gb3_pkg::cfg_idx_t cfg_index,
  input  gb3_pkg::dim_t    cfg_data
);
  import gb3_pkg::*;

  // configuration registers, latched into the frame at its first request
  dim_t width_r, width_nxt;
  dim_t height_r, height_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  width_nxt  = cfg_data;
        REG_IMAGE_HEIGHT: height_nxt = cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= CFG_RESET;
      height_r <= CFG_RESET;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Accept: counters decide what the request does; row memories are read here.
  // ---------------------------------------------------------------------------
  logic      accept;
  item_ctl_t ctl;
  addr_t     push_col, store_addr;
  pix_t      push_pix;

  assign accept = in_valid && in_ready;

  gb3_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .op         (in_operation),
    .pix        (in_pixel_in),
    .cfg_width  (width_r),
    .cfg_height (height_r),
    .ctl        (ctl),
    .push_col   (push_col),
    .store_addr (store_addr),
    .push_pix   (push_pix)
  );

  // ---------------------------------------------------------------------------
  // Read stage: memory data available, window shifts and result is formed.
  // Ignored flushes never enter it.
  // ---------------------------------------------------------------------------
  logic      sa_valid_r, sa_valid_nxt;
  item_ctl_t sa_ctl_r;
  addr_t     sa_col_r;
  pix_t      sa_pix_r;
  logic      sa_adv;
  logic      out_valid_r, out_valid_nxt;

  // stage moves on unless it holds a result and the output register is stuck
  assign sa_adv   = sa_valid_r && (!sa_ctl_r.emit || !out_valid_r || out_ready);
  assign in_ready = !sa_valid_r || sa_adv;

  always_comb begin
    sa_valid_nxt = sa_valid_r;
    if (accept) begin
      sa_valid_nxt = ctl.push || ctl.drain;
    end else if (sa_adv) begin
      sa_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sa_valid_r <= 1'b0;
    end else begin
      sa_valid_r <= sa_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sa_ctl_r <= ctl;
      sa_col_r <= push_col;
      sa_pix_r <= push_pix;
    end
  end

  pix_t up_q, mid_q, result;

  gb3_line_store u_line_store (
    .clk         (clk),
    .rst_n       (rst_n),
    .rd_en       (accept),
    .rd_addr_up  (push_col),
    .rd_addr_mid (store_addr),
    .mid_we      (accept && ctl.push),
    .mid_waddr   (push_col),
    .mid_wdata   (push_pix),
    .up_we       (sa_adv && sa_ctl_r.push),
    .up_waddr    (sa_col_r),
    .up_q        (up_q),
    .mid_q       (mid_q)
  );

  gb3_window u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .shift_en  (sa_adv && sa_ctl_r.push),
    .new_up    (up_q),
    .new_mid   (mid_q),
    .new_low   (sa_pix_r),
    .drain     (sa_ctl_r.drain),
    .border    (sa_ctl_r.border),
    .store_pix (mid_q),
    .result    (result)
  );

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  pix_t out_pix_r;
  logic out_end_r;
  logic out_load;

  assign out_load = sa_adv && sa_ctl_r.emit;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pix_r <= result;
      out_end_r <= sa_ctl_r.last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pixel_out = out_pix_r;
  assign out_frame_end = out_end_r;

endmodule

`default_nettype wire

// ----- tb/sv/gb3_blur_checker.sv -----
`timescale 1ns / 100ps
// gb3_blur_checker: passive monitor for gaussian_blur_3x3_top. Tracks geometry
// writes, predicts each result of the 3x3 blur and compares it. Needs gb3_pkg.

module gb3_blur_checker
  import gb3_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_ready,
  input  op_t      in_operation,
  input  pix_t     in_pixel_in,
  input  logic     out_valid,
  input  logic     out_ready,
  input  pix_t     out_pixel_out,
  input  logic     out_frame_end,
  input  logic     cfg_valid,
  input  logic     cfg_ready,
  input  cfg_idx_t cfg_index,
  input  dim_t     cfg_data,
  output int       fail_count,
  output int       pending,
  output int       results_seen,
  output logic     frame_open
);

  localparam int unsigned HEIGHT_CAP = 1023;

  typedef struct packed {
    pix_t pixel;
    logic frame_end;
  } blur_out_t;

  blur_out_t   expected_pixels[$];
  pix_t        upper_row [MAX_WIDTH];
  pix_t        middle_row[MAX_WIDTH];
  pix_t        win [3][3];
  int unsigned in_row, in_col, out_cnt;
  int unsigned frame_w, frame_h;
  dim_t        image_w, image_h;

  function automatic int unsigned effective_dim(input dim_t v, input int unsigned cap);
    if (v == 0) return 1;
    if (v > cap) return cap;
    return v;
  endfunction

  function automatic pix_t blurred_center();
    int unsigned s;
    s = win[0][0] + 2 * win[0][1] + win[0][2]
      + 2 * win[1][0] + 4 * win[1][1] + 2 * win[1][2]
      + win[2][0] + 2 * win[2][1] + win[2][2];
    return pix_t'(s >> 4);
  endfunction

  task automatic clear_state();
    int i;
    int r;
    for (i = 0; i < MAX_WIDTH; i++) begin
      upper_row[i]  = '0;
      middle_row[i] = '0;
    end
    for (r = 0; r < 3; r++) begin
      win[r][0] = '0;
      win[r][1] = '0;
      win[r][2] = '0;
    end
    in_row  = 0;
    in_col  = 0;
    out_cnt = 0;
    frame_w = 1;
    frame_h = 1;
    image_w = CFG_RESET;
    image_h = CFG_RESET;
    expected_pixels.delete();
  endtask

  // slide window left, pull the column from the row stores, rotate the stores
  task automatic shift_in(input pix_t v);
    int unsigned col;
    int r;
    col = (in_col < MAX_WIDTH) ? in_col : 0;
    for (r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2]       = upper_row[col];
    win[1][2]       = middle_row[col];
    win[2][2]       = v;
    upper_row[col]  = middle_row[col];
    middle_row[col] = v;
    in_col++;
    if (in_col >= frame_w) begin
      in_col = 0;
      in_row++;
    end
  endtask

  task automatic predict_request(input op_t op, input pix_t pix);
    int unsigned total;
    int unsigned r;
    int unsigned c;
    pix_t        val;
    logic        full;
    logic        last;
    if (in_row == 0 && in_col == 0 && out_cnt == 0) begin
      frame_w = effective_dim(image_w, MAX_WIDTH);
      frame_h = effective_dim(image_h, HEIGHT_CAP);
    end
    full = (in_row >= frame_h);
    if (op == OP_FLUSH && !full) return;
    total = frame_w * frame_h;
    if (full && frame_h == 1) begin
      // one-row frame: drain straight from the middle store
      val = middle_row[(out_cnt < MAX_WIDTH) ? out_cnt : 0];
    end else begin
      shift_in(full ? pix_t'(0) : pix);
      if (in_row * frame_w + in_col < frame_w + 2) return;
      r = out_cnt / frame_w;
      c = out_cnt % frame_w;
      if (r == 0 || r + 1 >= frame_h || c == 0 || c + 1 >= frame_w)
        val = win[1][1];
      else
        val = blurred_center();
    end
    out_cnt++;
    last = (out_cnt >= total);
    expected_pixels.push_back('{pixel: val, frame_end: last});
    if (last) begin
      in_row  = 0;
      in_col  = 0;
      out_cnt = 0;
    end
  endtask

  always @(posedge clk) begin : watch
    blur_out_t want;
    if (!rst_n) begin
      clear_state();
      fail_count   = 0;
      results_seen = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_IMAGE_WIDTH:  image_w = cfg_data;
          REG_IMAGE_HEIGHT: image_h = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        predict_request(in_operation, in_pixel_in);
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_pixels.size() == 0) begin
          $error("unexpected result: pixel_out=%0d frame_end=%0b",
                 out_pixel_out, out_frame_end);
          fail_count++;
        end else begin
          want = expected_pixels.pop_front();
          if (out_pixel_out !== want.pixel) begin
            $error("pixel_out mismatch: expected %0d, got %0d", want.pixel, out_pixel_out);
            fail_count++;
          end
          if (out_frame_end !== want.frame_end) begin
            $error("frame_end mismatch: expected %0b, got %0b",
                   want.frame_end, out_frame_end);
            fail_count++;
          end
        end
      end
    end
    pending    <= expected_pixels.size();
    frame_open <= (in_row != 0) || (in_col != 0) || (out_cnt != 0);
  end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// tb_top: stimulus and verdict for gaussian_blur_3x3_top.
// Depends on gb3_pkg, the block under src and gb3_blur_checker.

module tb_top;
  import gb3_pkg::*;

  localparam int RAND_ITEMS    = 280;
  localparam int SETTLE_CYCLES = 4;       // settle wait after the last result is out
  localparam int HOLD_CYCLES   = 300;     // long output hold-off
  localparam int CYCLE_LIMIT   = 400_000;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  op_t      in_operation = OP_PIXEL;
  pix_t     in_pixel_in = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  pix_t     out_pixel_out;
  logic     out_frame_end;
  logic     cfg_valid = 1'b0;
  logic     cfg_ready;
  cfg_idx_t cfg_index = REG_IMAGE_WIDTH;
  dim_t     cfg_data = '0;

  int       fail_count;
  int       pending;
  int       results_seen;
  logic     frame_open;

  int       cycle_count = 0;
  int       req_count = 0;
  int       frame_count = 0;
  int       send_idle_pct = 0;   // percent of cycles the sender holds valid low
  int       rx_stall_pct = 0;    // percent of cycles the receiver drops ready
  int       hold_token = 0;      // bump to start one long hold-off
  int       hold_seen = 0;
  int       hold_left = 0;

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  gaussian_blur_3x3_top u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_operation  (in_operation),
    .in_pixel_in   (in_pixel_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_pixel_out (out_pixel_out),
    .out_frame_end (out_frame_end),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  gb3_blur_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_operation  (in_operation),
    .in_pixel_in   (in_pixel_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_pixel_out (out_pixel_out),
    .out_frame_end (out_frame_end),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending       (pending),
    .results_seen  (results_seen),
    .frame_open    (frame_open)
  );

  // Watchdog: covers hung handshakes and results that never show up.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Result side. A hold-off request parks ready low while hold_left counts down
  // from HOLD_CYCLES; otherwise ready follows the current stall percentage.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_token) begin
      hold_seen <= hold_token;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  // Mostly random grey levels, with black and white well represented so the
  // weighted sum hits both ends.
  function automatic pix_t rand_pixel();
    case ($urandom_range(0, 7))
      0:       return '0;
      1, 2:    return '1;
      default: return pix_t'($urandom_range(0, 255));
    endcase
  endfunction

  // One request. Random idle cycles first (valid low), then valid stays up
  // until the block takes it. Valid is left high on return so a following
  // request can go back to back.
  task automatic send_item(input op_t op, input pix_t pix);
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_pixel_in  <= pix;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    req_count++;
  endtask

  // Stop offering requests and wait until every predicted result is out,
  // then a settle wait so nothing is left in the pipe.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input dim_t val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Program both geometry registers while idle; hands back the geometry the
  // block will actually use (0 counts as 1, width capped at MAX_WIDTH).
  task automatic set_geometry(input dim_t w, input dim_t h,
                              output int unsigned ew, output int unsigned eh);
    wait_idle();
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    cfg_valid <= 1'b0;
    ew = (w == 0) ? 1 : ((w > WIDTH_MAX) ? MAX_WIDTH : w);
    eh = (h == 0) ? 1 : h;
  endtask

  // Well-formed frame: every pixel, then exactly the flushes that drain it.
  // A one-row frame drains width results, taller frames width+1.
  task automatic send_frame(input int unsigned w, input int unsigned h);
    repeat (w * h) send_item(OP_PIXEL, rand_pixel());
    repeat ((h == 1) ? w : w + 1) send_item(OP_FLUSH, rand_pixel());
    frame_count++;
  endtask

  // Pixels finish whatever frame is open: they fill it or, once it is full,
  // act as drains. Keeps later frames aligned after a broken sequence.
  task automatic close_frame();
    in_valid <= 1'b0;
    @(posedge clk);
    while (frame_open) begin
      send_item(OP_PIXEL, rand_pixel());
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  initial begin
    int unsigned ew;
    int unsigned eh;
    int          k;
    int          n;
    int          start_reqs;
    int          phase;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---------------- directed ----------------
    // 3x3 frame, black/white checkerboard. Leading flush has nothing pending,
    // a flush in the middle comes before the frame is full: both ignored.
    // After the last pixel two more pixels act as drains, then two flushes.
    set_geometry(3, 3, ew, eh);
    send_item(OP_FLUSH, '1);
    for (k = 0; k < 9; k++) begin
      if (k == 4) send_item(OP_FLUSH, '0);
      send_item(OP_PIXEL, k[0] ? pix_t'('1) : pix_t'('0));
    end
    send_item(OP_PIXEL, '1);
    send_item(OP_PIXEL, '0);
    send_item(OP_FLUSH, '0);
    send_item(OP_FLUSH, '1);
    frame_count++;

    // zero geometry counts as 1x1
    set_geometry(0, 0, ew, eh);
    send_frame(ew, eh);

    // one-row frame: results come out of the row store on the drains
    set_geometry(4, 1, ew, eh);
    send_frame(ew, eh);

    // geometry rewritten mid-frame: the 3x2 frame keeps its latched size,
    // 2x4 applies to the next one
    set_geometry(3, 2, ew, eh);
    send_item(OP_PIXEL, rand_pixel());
    send_item(OP_PIXEL, rand_pixel());
    set_geometry(2, 4, ew, eh);
    repeat (4) send_item(OP_PIXEL, rand_pixel());
    repeat (4) send_item(OP_FLUSH, rand_pixel());
    frame_count++;
    send_frame(ew, eh);

    // ---------------- random frames ----------------
    // Handshake profile rotates per frame: none, sender idle, receiver
    // stalling, both, none again.
    start_reqs = req_count;
    phase = 0;
    while (req_count - start_reqs < RAND_ITEMS) begin
      case (phase % 5)
        1:       begin send_idle_pct = 55; rx_stall_pct <= 0;  end
        2:       begin send_idle_pct = 0;  rx_stall_pct <= 55; end
        3:       begin send_idle_pct = 36; rx_stall_pct <= 36; end
        default: begin send_idle_pct = 0;  rx_stall_pct <= 0;  end
      endcase
      phase++;
      if ($urandom_range(0, 7) == 0)
        set_geometry(dim_t'($urandom_range(1, 48)), dim_t'($urandom_range(1, 6)), ew, eh);
      else
        set_geometry(dim_t'($urandom_range(1, 10)), dim_t'($urandom_range(1, 8)), ew, eh);
      if ($urandom_range(0, 9) < 7) begin
        send_frame(ew, eh);
      end else begin
        // broken sequence: stray flushes, extra pixels, then close it out
        n = ew * eh + ew + $urandom_range(0, 4);
        repeat (n)
          send_item(($urandom_range(0, 99) < 30) ? OP_FLUSH : OP_PIXEL, rand_pixel());
        close_frame();
        frame_count++;
      end
    end

    // ---------------- back-pressure ----------------
    // Receiver holds off for a long stretch while the sender keeps pushing;
    // the block has to fill and stall its input.
    send_idle_pct = 0;
    rx_stall_pct <= 0;
    set_geometry(16, 8, ew, eh);
    hold_token <= hold_token + 1;
    send_frame(ew, eh);

    // ---------------- odd shapes ----------------
    // one pixel wide and tall under receiver stalls, then a wide short frame
    // with both sides idling
    rx_stall_pct <= 55;
    set_geometry(1, 40, ew, eh);
    send_frame(ew, eh);
    send_idle_pct = 36;
    rx_stall_pct <= 36;
    set_geometry(24, 3, ew, eh);
    send_frame(ew, eh);
    send_idle_pct = 0;
    rx_stall_pct <= 0;

    // drain everything, then a quiet tail to catch stray results
    wait_idle();
    repeat (10) @(posedge clk);

    $display("Sent %0d requests in %0d frames, checked %0d results.",
             req_count, frame_count, results_seen);
    $display("Frames from 1x1 to 48 wide and 40 high, four idle profiles, one long hold-off.");
    if (fail_count == 0 && pending == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
